[design/lctt_pkg.sv]
// lctt_pkg: types and constants of the learned capture trigger table.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps

package lctt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int PROB_W = 17;
  localparam logic [PROB_W-1:0] ONE_FIX = 17'h10000;
  localparam int STEP_W = $clog2(PROB_W);
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_CONF = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROB_THR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_PROB = 2'd2;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_LEARN = 1'b1;

  typedef struct packed {
    logic              func;
    logic [7:0]        species;
    logic [7:0]        behavior_code;
    logic [4:0]        hour_of_day;
    logic [PROB_W-1:0] overall_confidence;
    logic              species_detected;
    logic              threat_detected;
    logic              was_useful;
  } item_t;

  typedef struct packed {
    logic              capture;
    logic [PROB_W-1:0] probability;
    logic              matched;
    logic              table_full;
  } result_t;

  typedef struct packed {
    logic [7:0]            species;
    logic [7:0]            behavior;
    logic [4:0]            hour;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] success;
    logic [PROB_W-1:0]     ratio;
  } entry_t;

endpackage

[design/lctt_if.sv]
// lctt_if: valid/ready channel interfaces for input and result words.
// Depends on lctt_pkg.
`timescale 1ns / 1ps

interface lctt_item_if;
  import lctt_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lctt_result_if;
  import lctt_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/learned_capture_trigger_table_unit.sv]
// learned_capture_trigger_table_unit: capture decision with a learned pattern table.
// Depends on lctt_pkg, lctt_if and lctt_div.
//
//   channel  dir  handshake          word
//   item     in   valid/ready        lctt_pkg::item_t
//   result   out  valid/ready        lctt_pkg::result_t
//   cfg_*    in   cfg_we, no wait    cfg_addr selects register, cfg_data 17 bits
//
// One word at a time. The table scan reads one entry per cycle from the
// table RAM: a miss scans all used entries, a hit stops the scan at the
// matching entry, and a learn that updates a count then runs the
// bit-serial divider. Reset empties the table through the fill
// count; no clearing pass. A new word is taken while a result waits.
`timescale 1ns / 1ps

module learned_capture_trigger_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  lctt_item_if.sink                       item,
  lctt_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [lctt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lctt_pkg::PROB_W-1:0]     cfg_data
);
  import lctt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state;
  logic [PROB_W-1:0]     high_conf;
  logic [PROB_W-1:0]     prob_thr;
  logic [PROB_W-1:0]     base_prob;
  logic [USED_W-1:0]     used;
  item_t                 it;
  logic [USED_W-1:0]     idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  entry_t                rd_data;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  entry_t                hit_data;
  logic [COUNT_BITS-1:0] upd_total;
  logic [COUNT_BITS-1:0] upd_success;
  logic [PROB_W-1:0]     res_prob;
  logic                  res_full;
  logic                  out_valid;
  result_t               out_word;
  entry_t                mem [TABLE_ENTRIES];

  logic                  key_eq;
  logic                  hit_now;
  logic                  issue;
  logic                  scan_end;
  logic                  tab_full;
  logic                  sat;
  logic                  div_start;
  logic                  div_done;
  logic [PROB_W-1:0]     div_quot;
  logic [COUNT_BITS-1:0] new_total;
  logic [COUNT_BITS-1:0] new_success;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;
  logic                  load;
  logic                  capture;

  assign item.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.payload = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_conf <= 17'd45875;
      prob_thr  <= 17'd32768;
      base_prob <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HIGH_CONF: high_conf <= cfg_data;
        REG_PROB_THR:  prob_thr <= cfg_data;
        REG_BASE_PROB: base_prob <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan: read entry idx, compare the registered entry in the cycle after
  assign key_eq = (rd_data.species == it.species) && (rd_data.behavior == it.behavior_code)
                  && ((it.func == FUNC_QUERY) || (rd_data.hour == it.hour_of_day));
  assign hit_now = rd_vld && key_eq && !hit;
  assign issue = (state == S_SCAN) && (idx < used) && !hit && !hit_now;
  assign scan_end = (state == S_SCAN) && !issue && !rd_vld;
  assign tab_full = (used == USED_W'(TABLE_ENTRIES));
  assign sat = (hit_data.total == COUNT_MAX);
  assign new_total = hit_data.total + COUNT_BITS'(1);
  assign new_success = hit_data.success + {{(COUNT_BITS-1){1'b0}}, it.was_useful};
  assign div_start = scan_end && (it.func == FUNC_LEARN) && hit && !sat;

  assign wr_en = (scan_end && (it.func == FUNC_LEARN) && !hit && !tab_full)
                 || ((state == S_DIV) && div_done);
  assign wr_addr = hit ? hit_idx : used[IDX_W-1:0];
  always_comb begin
    wr_data.species  = it.species;
    wr_data.behavior = it.behavior_code;
    wr_data.hour     = it.hour_of_day;
    wr_data.total    = hit ? upd_total : COUNT_BITS'(1);
    wr_data.success  = hit ? upd_success : {{(COUNT_BITS-1){1'b0}}, it.was_useful};
    wr_data.ratio    = hit ? div_quot : (it.was_useful ? ONE_FIX : '0);
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  lctt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (new_success),
    .den   (new_total),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      rd_vld <= issue;
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_SCAN;
            hit   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            hit <= 1'b1;
          end
          if (scan_end) begin
            if (div_start) begin
              state <= S_DIV;
            end else begin
              state <= S_DONE;
            end
            if ((it.func == FUNC_LEARN) && !hit && !tab_full) begin
              used <= used + USED_W'(1);
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      it  <= item.payload;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + USED_W'(1);
    end
    if (issue) begin
      rd_idx <= idx[IDX_W-1:0];
    end
    if (hit_now) begin
      hit_idx  <= rd_idx;
      hit_data <= rd_data;
    end
    if (div_start) begin
      upd_total   <= new_total;
      upd_success <= new_success;
    end
    if (scan_end) begin
      res_full <= 1'b0;
      if (it.func == FUNC_QUERY) begin
        res_prob <= hit ? hit_data.ratio : base_prob;
      end else if (hit) begin
        res_prob <= hit_data.ratio;
      end else if (tab_full) begin
        res_prob <= '0;
        res_full <= 1'b1;
      end else begin
        res_prob <= it.was_useful ? ONE_FIX : '0;
      end
    end else if ((state == S_DIV) && div_done) begin
      res_prob <= div_quot;
    end
  end

  // result register
  assign load = (state == S_DONE) && (!out_valid || result.ready);
  assign capture = (it.func == FUNC_QUERY)
                   && ((it.overall_confidence > high_conf) || it.species_detected
                       || it.threat_detected || (res_prob > prob_thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word.capture     <= capture;
      out_word.probability <= res_prob;
      out_word.matched     <= hit;
      out_word.table_full  <= res_full;
    end
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == S_SCAN)
    else $error("accepted word did not start a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_div_learn_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (it.func == FUNC_LEARN) && hit)
    else $error("divider run without a matching learn");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.table_full |-> !out_word.matched && (out_word.probability == '0))
    else $error("table full result carries a match or a probability");

endmodule

[design/lctt_div.sv]
// lctt_div: restoring divider, one quotient bit per cycle,
// ratio = floor(num * 2^16 / den) for num <= den. Depends on lctt_pkg.
`timescale 1ns / 1ps

module lctt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lctt_pkg::COUNT_BITS-1:0] num,
  input  logic [lctt_pkg::COUNT_BITS-1:0] den,
  output logic                           done,
  output logic [lctt_pkg::PROB_W-1:0]     quot
);
  import lctt_pkg::*;

  logic                  busy;
  logic [STEP_W-1:0]     cnt;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS:0]   trial;
  logic                  ge;

  // first step compares num itself (quotient bit for 1.0), later steps shift
  assign trial = (cnt == STEP_W'(PROB_W - 1)) ? rem : {rem[COUNT_BITS-1:0], 1'b0};
  assign ge = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(PROB_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dsr  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? (trial - {1'b0, dsr}) : trial;
      quot <= {quot[PROB_W-2:0], ge};
    end
  end

endmodule

[tb/sv/tb_learned_capture_trigger_table_unit.sv]
// Self-checking bench for learned_capture_trigger_table_unit: directed rows,
// then random traffic under several threshold settings.
// Depends on lctt_pkg and lctt_if; expected words are typed or from the table model.
`timescale 1ns / 1ps

module tb_learned_capture_trigger_table_unit;
  import lctt_pkg::*;

  localparam int MAX_CYCLES = 1_000_000;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 320;
  localparam int POOL_KEYS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [PROB_W-1:0] HIGH_CONF_RST = 17'd45875;
  localparam logic [PROB_W-1:0] PROB_THR_RST = 17'd32768;
  localparam logic [PROB_W-1:0] BASE_PROB_RST = 17'd32768;
  localparam logic [PROB_W-1:0] PROB_ALL_ONES = 17'h1FFFF;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [PROB_W-1:0] cfg_data;

  lctt_item_if item_ch ();
  lctt_result_if result_ch ();

  learned_capture_trigger_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // table model
  logic [PROB_W-1:0] high_conf = HIGH_CONF_RST;
  logic [PROB_W-1:0] prob_thr = PROB_THR_RST;
  logic [PROB_W-1:0] base_prob = BASE_PROB_RST;
  entry_t tbl [TABLE_ENTRIES];
  bit tbl_valid [TABLE_ENTRIES];
  int unsigned tbl_used = 0;

  result_t decisions_due [$];
  entry_t key_pool [POOL_KEYS];
  dir_row_t dir_rows [$];
  int mismatches = 0;
  int words_checked = 0;
  int cycle_count = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic item_t mk_item(logic func, logic [7:0] sp, logic [7:0] bh,
                                    logic [4:0] hr, logic [PROB_W-1:0] conf,
                                    logic sdet, logic tdet, logic useful);
    item_t w;
    w.func = func;
    w.species = sp;
    w.behavior_code = bh;
    w.hour_of_day = hr;
    w.overall_confidence = conf;
    w.species_detected = sdet;
    w.threat_detected = tdet;
    w.was_useful = useful;
    return w;
  endfunction

  function automatic result_t mk_res(logic cap, logic [PROB_W-1:0] prob, logic hit,
                                     logic full);
    result_t r;
    r.capture = cap;
    r.probability = prob;
    r.matched = hit;
    r.table_full = full;
    return r;
  endfunction

  task automatic add_row(item_t w, bit typed, result_t want);
    dir_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Advances the table model by one word and returns the decision it makes.
  function automatic result_t decide_and_learn(item_t w);
    result_t r;
    int hit;
    int i;
    longint unsigned num;
    r = '0;
    hit = -1;
    if (w.func == FUNC_QUERY) begin
      r.probability = base_prob;
      for (i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && tbl_valid[i] && tbl[i].species == w.species &&
            tbl[i].behavior == w.behavior_code)
          hit = i;
      if (hit >= 0) begin
        r.probability = tbl[hit].ratio;
        r.matched = 1'b1;
      end
      r.capture = (w.overall_confidence > high_conf) || w.species_detected ||
                  w.threat_detected || (r.probability > prob_thr);
    end else begin
      for (i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && tbl_valid[i] && tbl[i].species == w.species &&
            tbl[i].behavior == w.behavior_code && tbl[i].hour == w.hour_of_day)
          hit = i;
      if (hit >= 0) begin
        r.matched = 1'b1;
        if (tbl[hit].total != COUNT_MAX) begin
          tbl[hit].total = tbl[hit].total + 1'b1;
          if (w.was_useful)
            tbl[hit].success = tbl[hit].success + 1'b1;
          num = longint'(tbl[hit].success) * 65536;
          tbl[hit].ratio = PROB_W'(num / tbl[hit].total);
        end
        r.probability = tbl[hit].ratio;
      end else if (tbl_used < TABLE_ENTRIES) begin
        tbl[tbl_used] = '{w.species, w.behavior_code, w.hour_of_day, COUNT_BITS'(1),
                          COUNT_BITS'(w.was_useful), w.was_useful ? ONE_FIX : '0};
        tbl_valid[tbl_used] = 1'b1;
        r.probability = tbl[tbl_used].ratio;
        tbl_used++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic item_t rand_item();
    item_t w;
    int k;
    w = '0;
    if ($urandom_range(0, 9) == 0) begin
      w.func = 1'($urandom);
      w.species = 8'($urandom);
      w.behavior_code = 8'($urandom);
      w.hour_of_day = 5'($urandom);
      w.overall_confidence = PROB_W'($urandom);
      w.species_detected = 1'($urandom);
      w.threat_detected = 1'($urandom);
      w.was_useful = 1'($urandom);
    end else begin
      k = $urandom_range(0, POOL_KEYS - 1);
      w.func = ($urandom_range(0, 1) == 1) ? FUNC_LEARN : FUNC_QUERY;
      w.species = key_pool[k].species;
      w.behavior_code = key_pool[k].behavior;
      w.hour_of_day = (w.func == FUNC_LEARN) ? key_pool[k].hour : 5'($urandom);
      case ($urandom_range(0, 5))
        0: w.overall_confidence = high_conf - 1'b1;
        1: w.overall_confidence = high_conf;
        2: w.overall_confidence = high_conf + 1'b1;
        3: w.overall_confidence = PROB_W'($urandom_range(0, 65536));
        4: w.overall_confidence = PROB_W'($urandom);
        default: w.overall_confidence = ONE_FIX;
      endcase
      w.species_detected = ($urandom_range(0, 4) == 0);
      w.threat_detected = ($urandom_range(0, 4) == 0);
      w.was_useful = 1'($urandom);
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result word %0d: %s", words_checked, msg);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (decisions_due.size() == 0) begin
      report_mismatch("result word with nothing pending");
    end else begin
      want = decisions_due.pop_front();
      if (got.capture !== want.capture)
        report_mismatch($sformatf("capture %0b, want %0b", got.capture, want.capture));
      if (got.probability !== want.probability)
        report_mismatch($sformatf("probability %0d, want %0d",
                                  got.probability, want.probability));
      if (got.matched !== want.matched)
        report_mismatch($sformatf("matched %0b, want %0b", got.matched, want.matched));
      if (got.table_full !== want.table_full)
        report_mismatch($sformatf("table_full %0b, want %0b",
                                  got.table_full, want.table_full));
    end
    words_checked++;
  endtask

  task automatic push_word(item_t w, bit typed, result_t want);
    result_t predicted;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= w;
    do @(posedge clk); while (!item_ch.ready);
    predicted = decide_and_learn(w);
    decisions_due.insert(decisions_due.size(), typed ? want : predicted);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (decisions_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [PROB_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    case (addr)
      REG_HIGH_CONF: high_conf = data;
      REG_PROB_THR: prob_thr = data;
      REG_BASE_PROB: base_prob = data;
      default: ;
    endcase
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        check_result(result_ch.payload);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int p;
    int n;
    int k;
    logic [PROB_W-1:0] hc;
    logic [PROB_W-1:0] pt;
    logic [PROB_W-1:0] bp;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.payload <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      tbl[k] = '0;
      tbl_valid[k] = 1'b0;
    end
    for (k = 0; k < POOL_KEYS; k++) begin
      key_pool[k] = '0;
      key_pool[k].species = 8'($urandom);
      key_pool[k].behavior = 8'($urandom);
      key_pool[k].hour = 5'($urandom);
      if (k % 4 == 3) begin
        // same species and behavior as the previous key, other hour
        key_pool[k].species = key_pool[k-1].species;
        key_pool[k].behavior = key_pool[k-1].behavior;
        key_pool[k].hour = key_pool[k-1].hour + 5'd1 + 5'($urandom_range(0, 29));
      end
    end

    // expected words typed in where they follow from the defaults and the earlier rows
    add_row(mk_item(FUNC_QUERY, 8'h00, 8'h00, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h00, 8'h00, 5'd0, 17'd45875, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h00, 8'h00, 5'd0, 17'd45876, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b1, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'hFF, 8'hFF, 5'd31, PROB_ALL_ONES, 1'b0, 1'b0, 1'b1),
            1'b1, mk_res(1'b1, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h12, 8'h34, 5'd3, 17'd0, 1'b1, 1'b0, 1'b0), 1'b1,
            mk_res(1'b1, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h12, 8'h34, 5'd3, 17'd0, 1'b0, 1'b1, 1'b0), 1'b1,
            mk_res(1'b1, 17'd32768, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h3C, 8'hC3, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk_item(FUNC_LEARN, 8'hFF, 8'hFF, 5'd31, PROB_ALL_ONES, 1'b1, 1'b1, 1'b1),
            1'b1, mk_res(1'b0, ONE_FIX, 1'b0, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'hFF, 8'hFF, 5'd31, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd32768, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'hFF, 8'hFF, 5'd31, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd21845, 1'b1, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'hFF, 8'hFF, 5'd0, 17'd0, 1'b0, 1'b0, 1'b1), 1'b1,
            mk_res(1'b0, 17'd21845, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'hFF, 8'hFF, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd0, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'hFF, 8'hFF, 5'd0, 17'd0, 1'b1, 1'b0, 1'b0), 1'b1,
            mk_res(1'b1, 17'd21845, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'h00, 8'h00, 5'd0, 17'd0, 1'b0, 1'b0, 1'b1), 1'b1,
            mk_res(1'b0, ONE_FIX, 1'b0, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h00, 8'h00, 5'd31, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b1, ONE_FIX, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'h00, 8'h00, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd32768, 1'b1, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h00, 8'h00, 5'd7, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b0, 17'd32768, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'h00, 8'h00, 5'd0, 17'd0, 1'b0, 1'b0, 1'b1), 1'b0, '0);
    add_row(mk_item(FUNC_LEARN, 8'h55, 8'hAA, 5'd21, 17'd0, 1'b0, 1'b0, 1'b1), 1'b1,
            mk_res(1'b0, ONE_FIX, 1'b0, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'h55, 8'hAA, 5'd21, 17'd0, 1'b0, 1'b0, 1'b1), 1'b1,
            mk_res(1'b0, ONE_FIX, 1'b1, 1'b0));
    add_row(mk_item(FUNC_QUERY, 8'h55, 8'hAA, 5'd9, 17'd0, 1'b0, 1'b0, 1'b0), 1'b1,
            mk_res(1'b1, ONE_FIX, 1'b1, 1'b0));
    add_row(mk_item(FUNC_LEARN, 8'h3C, 8'hC3, 5'd7, 17'd0, 1'b0, 1'b0, 1'b1), 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (k = 0; k < dir_rows.size(); k++)
      push_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin hc = HIGH_CONF_RST; pt = PROB_THR_RST; bp = BASE_PROB_RST; end
        1: begin hc = '0; pt = '0; bp = '0; end
        2: begin hc = ONE_FIX; pt = ONE_FIX; bp = ONE_FIX; end
        3: begin hc = PROB_ALL_ONES; pt = PROB_ALL_ONES; bp = '0; end
        4: begin
          hc = PROB_W'($urandom_range(0, 65536));
          pt = PROB_W'($urandom_range(0, 65536));
          bp = PROB_W'($urandom_range(0, 65536));
        end
        default: begin
          hc = HIGH_CONF_RST;
          pt = PROB_W'($urandom_range(16384, 49152));
          bp = PROB_W'($urandom);
        end
      endcase
      write_reg(REG_HIGH_CONF, hc);
      write_reg(REG_PROB_THR, pt);
      write_reg(REG_BASE_PROB, bp);
      if (p == 4)
        write_reg(REG_UNUSED, PROB_W'($urandom));
      cfg_we <= 1'b0;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 64 == 0) begin
          tx_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
          rx_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        if (p == 1 && n == 100)
          hold_req = 1'b1;
        if (p == 2 && n == 160)
          drain();
        push_word(rand_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
design/lctt_pkg.sv
design/lctt_if.sv
design/lctt_div.sv
design/learned_capture_trigger_table_unit.sv
tb/sv/tb_learned_capture_trigger_table_unit.sv
